// ===== hw/rtl/fcls_pkg.sv =====
// ----------------------------------------------------------------------------
// fcls_pkg
// Types, constants and codes shared by the circular flash log sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fcls_pkg;

  localparam int SECTOR_BYTES = 4096;
  localparam int LOG_COUNT    = 2;
  localparam int HEADER_BYTES = 4;

  localparam int NUM_LOG_REGS = 2;
  localparam int SECTOR_BITS  = $clog2(SECTOR_BYTES);
  localparam int LOG_IDX_W    = 1;

  localparam int ADDR_W   = 24;
  localparam int OFS_W    = 24;
  localparam int LIMIT_W  = 25;
  localparam int CNT_W    = 13;
  localparam int SERIAL_W = 16;
  localparam int PAY_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam int SECT_IDX_W = OFS_W - SECTOR_BITS;
  localparam int SCT_W      = (CNT_W > SECT_IDX_W) ? CNT_W : SECT_IDX_W;
  localparam int PROD_W     = SCT_W + SECTOR_BITS;

  localparam int MAX_RES = 3;
  localparam int RES_CNT_W = 2;

  localparam logic [15:0] USED_MARK = 16'hA5A5;

  localparam logic [ADDR_W-1:0]  RST_BASE_LOG0  = 24'd0;
  localparam logic [LIMIT_W-1:0] RST_LIMIT_LOG0 = 25'd65536;
  localparam logic [CNT_W-1:0]   RST_COUNT_LOG0 = 13'd16;
  localparam logic [ADDR_W-1:0]  RST_BASE_LOG1  = 24'd65536;
  localparam logic [LIMIT_W-1:0] RST_LIMIT_LOG1 = 25'd65536;
  localparam logic [CNT_W-1:0]   RST_COUNT_LOG1 = 13'd16;

  typedef enum logic [1:0] {
    OP_APPEND   = 2'd0,
    OP_READ     = 2'd1,
    OP_SIZE     = 2'd2,
    OP_RESERVED = 2'd3
  } fcls_op_e;

  typedef enum logic [2:0] {
    CMD_ERASE  = 3'd0,
    CMD_HEADER = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_NODATA = 3'd4,
    CMD_SIZE   = 3'd5
  } fcls_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_LOG0  = 3'd0,
    REG_LIMIT_LOG0 = 3'd1,
    REG_COUNT_LOG0 = 3'd2,
    REG_BASE_LOG1  = 3'd3,
    REG_LIMIT_LOG1 = 3'd4,
    REG_COUNT_LOG1 = 3'd5
  } fcls_reg_e;

  typedef struct packed {
    logic [1:0] operation;
    logic       log_select;
    logic [7:0] data_byte;
    logic       record_end;
  } fcls_item_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [ADDR_W-1:0] flash_address;
    logic [PAY_W-1:0]  payload;
    logic              record_done;
    logic              last;
  } fcls_result_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base_address;
    logic [LIMIT_W-1:0] size_limit;
    logic [CNT_W-1:0]   sector_count;
  } fcls_log_cfg_t;

  typedef struct packed {
    logic [OFS_W-1:0]    wr_ptr;
    logic [OFS_W-1:0]    rd_ptr;
    logic [SERIAL_W-1:0] next_serial;
  } fcls_log_state_t;

  typedef struct packed {
    logic                 push;
    logic [RES_CNT_W-1:0] push_count;
  } fcls_push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fcls_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fcls_cfg_regs
// Configuration registers for both logs, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module fcls_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [fcls_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fcls_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output fcls_pkg::fcls_log_cfg_t               log_cfg_o [fcls_pkg::NUM_LOG_REGS]
);

  fcls_pkg::fcls_log_cfg_t cfg_q [fcls_pkg::NUM_LOG_REGS];
  fcls_pkg::fcls_log_cfg_t cfg_d [fcls_pkg::NUM_LOG_REGS];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        fcls_pkg::REG_BASE_LOG0:  cfg_d[0].base_address = cfg_wdata_i[fcls_pkg::ADDR_W-1:0];
        fcls_pkg::REG_LIMIT_LOG0: cfg_d[0].size_limit   = cfg_wdata_i[fcls_pkg::LIMIT_W-1:0];
        fcls_pkg::REG_COUNT_LOG0: cfg_d[0].sector_count = cfg_wdata_i[fcls_pkg::CNT_W-1:0];
        fcls_pkg::REG_BASE_LOG1:  cfg_d[1].base_address = cfg_wdata_i[fcls_pkg::ADDR_W-1:0];
        fcls_pkg::REG_LIMIT_LOG1: cfg_d[1].size_limit   = cfg_wdata_i[fcls_pkg::LIMIT_W-1:0];
        fcls_pkg::REG_COUNT_LOG1: cfg_d[1].sector_count = cfg_wdata_i[fcls_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= '{base_address: fcls_pkg::RST_BASE_LOG0,
                    size_limit:   fcls_pkg::RST_LIMIT_LOG0,
                    sector_count: fcls_pkg::RST_COUNT_LOG0};
      cfg_q[1] <= '{base_address: fcls_pkg::RST_BASE_LOG1,
                    size_limit:   fcls_pkg::RST_LIMIT_LOG1,
                    sector_count: fcls_pkg::RST_COUNT_LOG1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign log_cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fcls_step.sv =====
// ----------------------------------------------------------------------------
// fcls_step
// Single-pass command generation and pointer update for one log.
// ----------------------------------------------------------------------------
`default_nettype none

module fcls_step (
  input  wire fcls_pkg::fcls_item_t             item_i,
  input  wire fcls_pkg::fcls_log_cfg_t          cfg_i,
  input  wire fcls_pkg::fcls_log_state_t        state_i,
  output fcls_pkg::fcls_log_state_t             state_o,
  output fcls_pkg::fcls_result_t                res_o [fcls_pkg::MAX_RES],
  output logic [fcls_pkg::RES_CNT_W-1:0]        count_o
);

  localparam int SB = fcls_pkg::SECTOR_BITS;
  localparam int OW = fcls_pkg::OFS_W;

  always_comb begin
    logic [OW-1:0]                   wo;
    logic [OW-1:0]                   ro;
    logic [fcls_pkg::ADDR_W-1:0]     addr;
    logic                            avail;
    logic [fcls_pkg::SCT_W-1:0]      sct;
    logic [fcls_pkg::PROD_W-1:0]     prod;
    logic [fcls_pkg::PAY_W-1:0]      size;
    logic [SB-1:0]                   rem;

    wo    = state_i.wr_ptr;
    ro    = state_i.rd_ptr;
    addr  = '0;
    avail = 1'b0;
    sct   = '0;
    prod  = '0;
    size  = '0;
    rem   = '0;
    state_o = state_i;
    count_o = '0;
    for (int k = 0; k < fcls_pkg::MAX_RES; k++) begin
      res_o[k] = '0;
    end

    case (item_i.operation)
      fcls_pkg::OP_APPEND: begin
        if (wo[SB-1:0] == '0) begin
          if ({1'b0, wo} >= cfg_i.size_limit) begin
            wo = '0;
          end
          addr = cfg_i.base_address + wo;
          res_o[0].command       = fcls_pkg::CMD_ERASE;
          res_o[0].flash_address = addr;
          res_o[1].command       = fcls_pkg::CMD_HEADER;
          res_o[1].flash_address = addr;
          res_o[1].payload       = {state_i.next_serial, fcls_pkg::USED_MARK};
          state_o.next_serial    = state_i.next_serial + 16'd1;
          wo = wo + OW'(fcls_pkg::HEADER_BYTES);
          res_o[2].command       = fcls_pkg::CMD_WRITE;
          res_o[2].flash_address = cfg_i.base_address + wo;
          res_o[2].payload       = {24'd0, item_i.data_byte};
          res_o[2].record_done   = item_i.record_end;
          res_o[2].last          = 1'b1;
          count_o = 2'd3;
        end else begin
          res_o[0].command       = fcls_pkg::CMD_WRITE;
          res_o[0].flash_address = cfg_i.base_address + wo;
          res_o[0].payload       = {24'd0, item_i.data_byte};
          res_o[0].record_done   = item_i.record_end;
          res_o[0].last          = 1'b1;
          count_o = 2'd1;
        end
        state_o.wr_ptr = wo + OW'(1);
      end
      fcls_pkg::OP_READ: begin
        if (ro[SB-1:0] == '0) begin
          if ({1'b0, ro} >= cfg_i.size_limit) begin
            ro = '0;
          end
          ro = ro + OW'(fcls_pkg::HEADER_BYTES);
        end
        avail = (ro[OW-1:SB] != wo[OW-1:SB]) || (wo > ro);
        if (avail) begin
          res_o[0].command       = fcls_pkg::CMD_READ;
          res_o[0].flash_address = cfg_i.base_address + ro;
          ro = ro + OW'(1);
        end else begin
          res_o[0].command = fcls_pkg::CMD_NODATA;
        end
        res_o[0].record_done = item_i.record_end;
        res_o[0].last        = 1'b1;
        state_o.rd_ptr       = ro;
        count_o = 2'd1;
      end
      fcls_pkg::OP_SIZE: begin
        if (ro > wo) begin
          sct = (cfg_i.sector_count != '0) ?
                fcls_pkg::SCT_W'(cfg_i.sector_count - 1'b1) : '0;
        end else begin
          sct = fcls_pkg::SCT_W'(wo[OW-1:SB]);
        end
        prod = fcls_pkg::PROD_W'(sct) *
               fcls_pkg::PROD_W'(fcls_pkg::SECTOR_BYTES - fcls_pkg::HEADER_BYTES);
        rem  = wo[SB-1:0];
        size = 32'(prod);
        if (rem >= SB'(fcls_pkg::HEADER_BYTES)) begin
          size = size + 32'(rem) - 32'(fcls_pkg::HEADER_BYTES);
        end
        res_o[0].command     = fcls_pkg::CMD_SIZE;
        res_o[0].payload     = size;
        res_o[0].record_done = item_i.record_end;
        res_o[0].last        = 1'b1;
        count_o = 2'd1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcls_result_queue.sv =====
// ----------------------------------------------------------------------------
// fcls_result_queue
// Result register: holds up to three beats of one item and shifts them out.
// ----------------------------------------------------------------------------
`default_nettype none

module fcls_result_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fcls_pkg::fcls_push_t  push_i,
  input  wire fcls_pkg::fcls_result_t push_res_i [fcls_pkg::MAX_RES],
  output logic                       ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output fcls_pkg::fcls_result_t     out_data_o
);

  logic [fcls_pkg::RES_CNT_W-1:0] count_q, count_d;
  fcls_pkg::fcls_result_t         slot_q [fcls_pkg::MAX_RES];
  fcls_pkg::fcls_result_t         slot_d [fcls_pkg::MAX_RES];
  logic                           pop;

  assign pop     = (count_q != '0) && !out_stall_i;
  assign ready_o = (count_q == '0) || ((count_q == 2'd1) && !out_stall_i);

  always_comb begin
    count_d = count_q;
    slot_d  = slot_q;
    if (push_i.push) begin
      count_d = push_i.push_count;
      slot_d  = push_res_i;
    end else if (pop) begin
      count_d = count_q - 2'd1;
      for (int k = 0; k < fcls_pkg::MAX_RES - 1; k++) begin
        slot_d[k] = slot_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = slot_q[0];

endmodule

`default_nettype wire

// ===== hw/rtl/flash_circular_log_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// flash_circular_log_sequencer_top
// Two circular logs in sectored flash: turns append, read and size items
// into erase, header, write and read commands for a flash controller.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | beat
//   in      | input     | in_valid_i/in_stall_o | fcls_item_t
//   out     | output    | out_valid_o/out_stall_i | fcls_result_t
//   cfg     | input     | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// One item is taken per cycle while the result register is ready; its first
// beat appears in the cycle after accept. A sector-start append yields three
// beats and holds the input while the result register drains; other appends,
// reads and sizes yield one beat, reserved items none. Reset clears all
// pointers and serials at once and loads register defaults. A stall on the
// output holds the result register and, while any beat is pending, the input.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_circular_log_sequencer_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire fcls_pkg::fcls_item_t             in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output fcls_pkg::fcls_result_t                out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [fcls_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fcls_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  fcls_pkg::fcls_log_cfg_t   log_cfg [fcls_pkg::NUM_LOG_REGS];
  fcls_pkg::fcls_log_state_t state_q [fcls_pkg::LOG_COUNT];
  fcls_pkg::fcls_log_state_t state_d [fcls_pkg::LOG_COUNT];
  fcls_pkg::fcls_log_state_t step_state;
  fcls_pkg::fcls_result_t    step_res [fcls_pkg::MAX_RES];
  logic [fcls_pkg::RES_CNT_W-1:0] step_count;
  fcls_pkg::fcls_push_t      push;
  logic                      q_ready;
  logic                      in_accept;
  logic [fcls_pkg::LOG_IDX_W-1:0] sel;

  assign in_stall_o = !q_ready;
  assign in_accept  = in_valid_i && q_ready;

  always_comb begin
    if (int'(in_data_i.log_select) >= fcls_pkg::LOG_COUNT) begin
      sel = fcls_pkg::LOG_IDX_W'(fcls_pkg::LOG_COUNT - 1);
    end else begin
      sel = in_data_i.log_select;
    end
  end

  fcls_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .log_cfg_o   (log_cfg)
  );

  fcls_step u_step (
    .item_i  (in_data_i),
    .cfg_i   (log_cfg[sel]),
    .state_i (state_q[sel]),
    .state_o (step_state),
    .res_o   (step_res),
    .count_o (step_count)
  );

  always_comb begin
    state_d = state_q;
    if (in_accept) begin
      state_d[sel] = step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < fcls_pkg::LOG_COUNT; k++) begin
        state_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
    end
  end

  assign push.push       = in_accept;
  assign push.push_count = step_count;

  fcls_result_queue u_result_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_res_i  (step_res),
    .ready_o     (q_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fcls_checker.sv =====
// ----------------------------------------------------------------------------
// fcls_checker
// Port-level checks for the circular flash log sequencer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fcls_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire fcls_pkg::fcls_item_t             in_data_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire fcls_pkg::fcls_result_t           out_data_o
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  a_item_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.operation != fcls_pkg::OP_RESERVED) |=> out_valid_o)
    else $error("accepted item produced no beat");

  a_erase_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (out_data_o.command == fcls_pkg::CMD_ERASE) |=>
      out_valid_o && (out_data_o.command == fcls_pkg::CMD_HEADER) && !out_data_o.last)
    else $error("erase not followed by header beat");

endmodule

bind flash_circular_log_sequencer_top fcls_checker u_fcls_checker (.*);

`default_nettype wire

// ===== dv/flash_circular_log_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// flash_circular_log_sequencer_top_tb
// Self-checking bench for the two-log circular flash sequencer: a directed
// table at reset and extreme settings, an append-heavy and a read-heavy
// sweep, then random items under several register settings. Every beat is
// scored against an in-bench predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_circular_log_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcls_pkg::*;

  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int FILL_ITEMS    = 40;
  localparam int DRAIN_ITEMS   = 30;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 24;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  typedef struct {
    bit                    setup;
    fcls_reg_e             reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    fcls_item_t            item;
    bit                    typed;
    fcls_result_t          final_beat;
  } dir_row_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  fcls_item_t            in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_stall;
  logic                  out_valid;
  fcls_result_t          out_data;

  fcls_log_cfg_t   log_cfg [LOG_COUNT];
  fcls_log_state_t log_st  [LOG_COUNT];
  fcls_result_t    due_cmds[$];

  int       fail_count    = 0;
  int       burst_left    = 0;
  int       hold_requests = 0;
  int       holds_done    = 0;
  int       hold_left     = 0;
  int       mode_left     = 0;
  rx_mode_e stall_mode    = RX_FREE;
  int       quiet_cycles  = 0;

  always #2 clk_i = ~clk_i;

  flash_circular_log_sequencer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  task automatic flag_mismatch(string what, logic [PAY_W-1:0] got, logic [PAY_W-1:0] want);
    $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic fcls_result_t flash_cmd(fcls_cmd_e cmd, logic [ADDR_W-1:0] addr,
                                             logic [PAY_W-1:0] pay);
    fcls_result_t r;
    r               = '0;
    r.command       = cmd;
    r.flash_address = addr;
    r.payload       = pay;
    return r;
  endfunction

  function automatic void issue_flash_cmds(fcls_item_t it);
    int unsigned       sel;
    int                first;
    logic [OFS_W-1:0]  wo;
    logic [OFS_W-1:0]  ro;
    logic [ADDR_W-1:0] addr;
    longint unsigned   stored;
    fcls_result_t      tail;
    first = due_cmds.size();
    sel   = it.log_select;
    if (sel >= LOG_COUNT) sel = LOG_COUNT - 1;
    wo = log_st[sel].wr_ptr;
    ro = log_st[sel].rd_ptr;
    case (fcls_op_e'(it.operation))
      OP_APPEND: begin
        if (wo[SECTOR_BITS-1:0] == '0) begin
          if ({1'b0, wo} >= log_cfg[sel].size_limit) wo = '0;
          addr = log_cfg[sel].base_address + wo;
          due_cmds.push_back(flash_cmd(CMD_ERASE, addr, '0));
          due_cmds.push_back(flash_cmd(CMD_HEADER, addr,
                                       {log_st[sel].next_serial, USED_MARK}));
          log_st[sel].next_serial = log_st[sel].next_serial + 1'b1;
          wo = wo + OFS_W'(HEADER_BYTES);
        end
        addr = log_cfg[sel].base_address + wo;
        due_cmds.push_back(flash_cmd(CMD_WRITE, addr, PAY_W'(it.data_byte)));
        log_st[sel].wr_ptr = wo + 1'b1;
      end
      OP_READ: begin
        if (ro[SECTOR_BITS-1:0] == '0) begin
          if ({1'b0, ro} >= log_cfg[sel].size_limit) ro = '0;
          ro = ro + OFS_W'(HEADER_BYTES);
        end
        if (ro[OFS_W-1:SECTOR_BITS] != wo[OFS_W-1:SECTOR_BITS] || wo > ro) begin
          addr = log_cfg[sel].base_address + ro;
          due_cmds.push_back(flash_cmd(CMD_READ, addr, '0));
          ro = ro + 1'b1;
        end else begin
          due_cmds.push_back(flash_cmd(CMD_NODATA, '0, '0));
        end
        log_st[sel].rd_ptr = ro;
      end
      OP_SIZE: begin
        if (ro > wo)
          stored = (log_cfg[sel].sector_count != '0) ?
                   64'(log_cfg[sel].sector_count) - 64'd1 : 64'd0;
        else
          stored = 64'(wo[OFS_W-1:SECTOR_BITS]);
        stored = stored * 64'(SECTOR_BYTES - HEADER_BYTES);
        if (wo[SECTOR_BITS-1:0] >= SECTOR_BITS'(HEADER_BYTES))
          stored = stored + 64'(wo[SECTOR_BITS-1:0]) - 64'(HEADER_BYTES);
        due_cmds.push_back(flash_cmd(CMD_SIZE, '0, stored[PAY_W-1:0]));
      end
      default: ;
    endcase
    if (due_cmds.size() > first) begin
      tail             = due_cmds.pop_back();
      tail.record_done = it.record_end;
      tail.last        = 1'b1;
      due_cmds.push_back(tail);
    end
  endfunction

  function automatic dir_row_t stim_row(fcls_op_e op, bit sel, logic [7:0] data, bit rend);
    dir_row_t r;
    r.setup           = 1'b0;
    r.reg_idx         = REG_BASE_LOG0;
    r.reg_val         = '0;
    r.item.operation  = op;
    r.item.log_select = sel;
    r.item.data_byte  = data;
    r.item.record_end = rend;
    r.typed           = 1'b0;
    r.final_beat      = '0;
    return r;
  endfunction

  function automatic dir_row_t known_row(fcls_op_e op, bit sel, logic [7:0] data, bit rend,
                                         fcls_cmd_e cmd, logic [ADDR_W-1:0] addr,
                                         logic [PAY_W-1:0] pay);
    dir_row_t r;
    r                        = stim_row(op, sel, data, rend);
    r.typed                  = 1'b1;
    r.final_beat             = flash_cmd(cmd, addr, pay);
    r.final_beat.record_done = rend;
    r.final_beat.last        = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t setup_row(fcls_reg_e idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r         = stim_row(OP_RESERVED, 1'b0, '0, 1'b0);
    r.setup   = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic fcls_item_t random_item(int unsigned append_pct, int unsigned read_pct,
                                             int unsigned size_pct);
    fcls_item_t  it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < append_pct)
      it.operation = OP_APPEND;
    else if (r < append_pct + read_pct)
      it.operation = OP_READ;
    else if (r < append_pct + read_pct + size_pct)
      it.operation = OP_SIZE;
    else
      it.operation = OP_RESERVED;
    it.log_select = 1'($urandom_range(0, 1));
    it.data_byte  = 8'($urandom);
    it.record_end = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic fcls_log_cfg_t random_log_cfg();
    fcls_log_cfg_t c;
    case ($urandom_range(0, 2))
      0:       c.base_address = '0;
      1:       c.base_address = '1;
      default: c.base_address = ADDR_W'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       c.size_limit = '0;
      1:       c.size_limit = LIMIT_W'(SECTOR_BYTES);
      2:       c.size_limit = 25'h1000000;
      3:       c.size_limit = LIMIT_W'(2 * SECTOR_BYTES);
      default: c.size_limit = LIMIT_W'($urandom_range(0, 25'h1000000));
    endcase
    case ($urandom_range(0, 3))
      0:       c.sector_count = '0;
      1:       c.sector_count = 13'd1;
      2:       c.sector_count = 13'd4096;
      default: c.sector_count = CNT_W'($urandom_range(1, 4096));
    endcase
    return c;
  endfunction

  task automatic write_reg(fcls_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      REG_BASE_LOG0:  log_cfg[0].base_address = val[ADDR_W-1:0];
      REG_LIMIT_LOG0: log_cfg[0].size_limit   = val[LIMIT_W-1:0];
      REG_COUNT_LOG0: log_cfg[0].sector_count = val[CNT_W-1:0];
      REG_BASE_LOG1:  log_cfg[1].base_address = val[ADDR_W-1:0];
      REG_LIMIT_LOG1: log_cfg[1].size_limit   = val[LIMIT_W-1:0];
      REG_COUNT_LOG1: log_cfg[1].sector_count = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_logs(fcls_log_cfg_t c0, fcls_log_cfg_t c1);
    write_reg(REG_BASE_LOG0, CFG_DATA_W'(c0.base_address));
    write_reg(REG_LIMIT_LOG0, c0.size_limit);
    write_reg(REG_COUNT_LOG0, CFG_DATA_W'(c0.sector_count));
    write_reg(REG_BASE_LOG1, CFG_DATA_W'(c1.base_address));
    write_reg(REG_LIMIT_LOG1, c1.size_limit);
    write_reg(REG_COUNT_LOG1, CFG_DATA_W'(c1.sector_count));
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left  = 0;
    while (due_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_item(fcls_item_t it, bit typed, fcls_result_t final_beat);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    burst_left--;
    issue_flash_cmds(it);
    if (typed) begin
      void'(due_cmds.pop_back());
      due_cmds.push_back(final_beat);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
        RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 80);
        default:  out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk_i) begin : score_beats
    fcls_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (due_cmds.size() == 0) begin
        flag_mismatch("beat with nothing due", out_data.payload, '0);
      end else begin
        want = due_cmds.pop_front();
        if (out_data.command !== want.command)
          flag_mismatch("command", PAY_W'(out_data.command), PAY_W'(want.command));
        if (out_data.flash_address !== want.flash_address)
          flag_mismatch("flash_address", PAY_W'(out_data.flash_address),
                        PAY_W'(want.flash_address));
        if (out_data.payload !== want.payload)
          flag_mismatch("payload", out_data.payload, want.payload);
        if (out_data.record_done !== want.record_done)
          flag_mismatch("record_done", PAY_W'(out_data.record_done), PAY_W'(want.record_done));
        if (out_data.last !== want.last)
          flag_mismatch("last", PAY_W'(out_data.last), PAY_W'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t      dir_tbl[$];
    bit            writing;
    fcls_log_cfg_t c0;
    fcls_log_cfg_t c1;
    writing    = 1'b0;
    log_cfg[0] = {RST_BASE_LOG0, RST_LIMIT_LOG0, RST_COUNT_LOG0};
    log_cfg[1] = {RST_BASE_LOG1, RST_LIMIT_LOG1, RST_COUNT_LOG1};
    log_st[0]  = '0;
    log_st[1]  = '0;

    dir_tbl.push_back(known_row(OP_SIZE, 1'b0, 8'h00, 1'b1, CMD_SIZE, '0, '0));
    dir_tbl.push_back(known_row(OP_READ, 1'b0, 8'h00, 1'b0, CMD_NODATA, '0, '0));
    dir_tbl.push_back(stim_row(OP_RESERVED, 1'b0, 8'hFF, 1'b1));
    dir_tbl.push_back(known_row(OP_APPEND, 1'b0, 8'hFF, 1'b1, CMD_WRITE, 24'h000004, 32'hFF));
    dir_tbl.push_back(known_row(OP_APPEND, 1'b1, 8'h00, 1'b0, CMD_WRITE, 24'h010004, 32'h00));
    dir_tbl.push_back(known_row(OP_READ, 1'b0, 8'h00, 1'b1, CMD_READ, 24'h000004, '0));
    dir_tbl.push_back(known_row(OP_READ, 1'b0, 8'hFF, 1'b0, CMD_NODATA, '0, '0));
    dir_tbl.push_back(known_row(OP_SIZE, 1'b0, 8'h00, 1'b0, CMD_SIZE, '0, 32'd1));
    dir_tbl.push_back(stim_row(OP_APPEND, 1'b1, 8'h5A, 1'b1));
    dir_tbl.push_back(stim_row(OP_READ, 1'b1, 8'hA5, 1'b0));
    dir_tbl.push_back(setup_row(REG_BASE_LOG0, 25'hFFFFFE));
    dir_tbl.push_back(setup_row(REG_LIMIT_LOG0, 25'h1000000));
    dir_tbl.push_back(setup_row(REG_COUNT_LOG0, 25'd4096));
    dir_tbl.push_back(setup_row(REG_BASE_LOG1, 25'hFFFFFF));
    dir_tbl.push_back(setup_row(REG_LIMIT_LOG1, 25'd0));
    dir_tbl.push_back(setup_row(REG_COUNT_LOG1, 25'd1));
    dir_tbl.push_back(known_row(OP_APPEND, 1'b0, 8'h80, 1'b0, CMD_WRITE, 24'h000003, 32'h80));
    dir_tbl.push_back(stim_row(OP_APPEND, 1'b0, 8'h01, 1'b1));
    dir_tbl.push_back(stim_row(OP_READ, 1'b0, 8'h00, 1'b1));
    dir_tbl.push_back(stim_row(OP_SIZE, 1'b1, 8'hFF, 1'b1));
    dir_tbl.push_back(stim_row(OP_APPEND, 1'b1, 8'h7F, 1'b0));
    dir_tbl.push_back(stim_row(OP_READ, 1'b1, 8'h00, 1'b0));
    dir_tbl.push_back(stim_row(OP_RESERVED, 1'b1, 8'h00, 1'b0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].setup) begin
        if (!writing) begin
          wait_idle();
          writing = 1'b1;
        end
        write_reg(dir_tbl[k].reg_idx, dir_tbl[k].reg_val);
      end else begin
        if (writing) begin
          cfg_we  <= 1'b0;
          writing  = 1'b0;
        end
        push_item(dir_tbl[k].item, dir_tbl[k].typed, dir_tbl[k].final_beat);
      end
    end
    wait_idle();

    // append-heavy sweep with tight size limits
    c0.base_address = ADDR_W'($urandom);
    c0.size_limit   = LIMIT_W'(SECTOR_BYTES);
    c0.sector_count = '0;
    c1.base_address = 24'hFFF000;
    c1.size_limit   = LIMIT_W'(2 * SECTOR_BYTES);
    c1.sector_count = 13'd4096;
    program_logs(c0, c1);
    repeat (FILL_ITEMS) push_item(random_item(85, 12, 3), 1'b0, '0);
    wait_idle();

    // read-heavy sweep: reads run past the write pointer
    c1.size_limit   = LIMIT_W'(SECTOR_BYTES);
    c1.sector_count = 13'd1;
    program_logs(c0, c1);
    repeat (DRAIN_ITEMS) push_item(random_item(15, 80, 5), 1'b0, '0);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_logs(random_log_cfg(), random_log_cfg());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 5) hold_requests++;
        push_item(random_item(50, 25, 15), 1'b0, '0);
      end
      wait_idle();
    end

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
